// ----- hw/rtl/mlr_pkg.sv -----
// mlr_pkg: shared widths, types and command/status structs for the
// midpoint line rasterizer. No dependencies.
`timescale 1ns / 1ps

package mlr_pkg;

  localparam int COORD_BITS = 6;
  localparam int DEC_BITS   = COORD_BITS + 4;

  typedef logic [COORD_BITS-1:0]       coord_t;
  typedef logic signed [DEC_BITS-1:0]  dec_t;

  typedef struct packed {
    logic load;
    logic step;
  } mlr_cmd_t;

  typedef struct packed {
    logic last;
  } mlr_sts_t;

  function automatic dec_t to_dec(input coord_t v);
    to_dec = dec_t'({{(DEC_BITS-COORD_BITS){1'b0}}, v});
  endfunction

endpackage

// ----- hw/rtl/mlr_if.sv -----
// Valid/ready channel interfaces: segment input and pixel output.
// Depends on mlr_pkg.
`timescale 1ns / 1ps

interface mlr_seg_if;
  logic            valid;
  logic            ready;
  mlr_pkg::coord_t start_x;
  mlr_pkg::coord_t start_y;
  mlr_pkg::coord_t end_x;
  mlr_pkg::coord_t end_y;

  modport source (output valid, output start_x, output start_y, output end_x,
                  output end_y, input ready);
  modport sink   (input valid, input start_x, input start_y, input end_x,
                  input end_y, output ready);
endinterface

interface mlr_pix_if;
  logic            valid;
  logic            ready;
  mlr_pkg::coord_t pixel_x;
  mlr_pkg::coord_t pixel_y;
  logic            last_pixel;

  modport source (output valid, output pixel_x, output pixel_y, output last_pixel,
                  input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input last_pixel,
                  output ready);
endinterface

// ----- hw/rtl/midpoint_line_rasterizer.sv -----
// midpoint_line_rasterizer: top level, joins mlr_ctrl and mlr_datapath.
// Depends on mlr_pkg, mlr_seg_if, mlr_pix_if.
`timescale 1ns / 1ps
//
// Usage:
//   in_seg  (sink)  : one segment per transaction, endpoints start/end.
//   out_pix (source): one pixel per transaction, last_pixel on the final one.
//   The endpoints are ordered by x; pixels come out with x never decreasing.
// The first pixel is valid in the cycle after the segment transaction.
// Throughput: one pixel per cycle while out_pix is ready; a segment with
//   major-axis length N yields N+1 pixels, and a new segment is taken only
//   in the idle state, once the last pixel of the previous one is taken.
// in_seg.ready is high only while no segment is in flight; it rises in the
//   cycle after the last pixel is taken.
// Reset (synchronous, rst_n low) returns the sequencer to idle and clears the
//   walk registers; no pixel is valid afterward.
// A stall on out_pix holds the current pixel and freezes the walk.

module midpoint_line_rasterizer (
  input  logic    clk,
  input  logic    rst_n,
  mlr_seg_if.sink   in_seg,
  mlr_pix_if.source out_pix
);

  mlr_pkg::mlr_cmd_t cmd;
  mlr_pkg::mlr_sts_t sts;

  mlr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_seg.valid),
    .in_ready (in_seg.ready),
    .out_valid(out_pix.valid),
    .out_ready(out_pix.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mlr_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .start_x(in_seg.start_x),
    .start_y(in_seg.start_y),
    .end_x  (in_seg.end_x),
    .end_y  (in_seg.end_y),
    .sts    (sts),
    .pixel_x(out_pix.pixel_x),
    .pixel_y(out_pix.pixel_y)
  );

  assign out_pix.last_pixel = sts.last;

endmodule

// ----- hw/rtl/mlr_ctrl.sv -----
// mlr_ctrl: sequencer for the rasterizer; loads a segment, then steps
// once per pixel transaction before the last. Depends on mlr_pkg.
`timescale 1ns / 1ps

module mlr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  mlr_pkg::mlr_sts_t sts,
  output mlr_pkg::mlr_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_xfer;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_RUN);
  assign out_xfer  = out_valid && out_ready;
  assign cmd.load  = in_valid && in_ready;
  assign cmd.step  = out_xfer && !sts.last;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_RUN;
      end
      S_RUN: begin
        if (out_xfer && sts.last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hw/rtl/mlr_datapath.sv -----
// mlr_datapath: endpoint ordering, slope classification and the midpoint
// decision walk. Depends on mlr_pkg.
`timescale 1ns / 1ps

module mlr_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  mlr_pkg::mlr_cmd_t cmd,
  input  mlr_pkg::coord_t   start_x,
  input  mlr_pkg::coord_t   start_y,
  input  mlr_pkg::coord_t   end_x,
  input  mlr_pkg::coord_t   end_y,
  output mlr_pkg::mlr_sts_t sts,
  output mlr_pkg::coord_t   pixel_x,
  output mlr_pkg::coord_t   pixel_y
);

  mlr_pkg::coord_t cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  mlr_pkg::coord_t stop_r, stop_nxt;
  mlr_pkg::dec_t   dec_r, dec_nxt, keep_r, keep_nxt, move_r, move_nxt;
  logic            down_r, down_nxt, steep_r, steep_nxt;

  mlr_pkg::coord_t x0, y0, x1, y1, adx, ady, major, minor;
  mlr_pkg::dec_t   major_d, minor_d;
  logic            swap, tie_ld, tie, move;

  always_comb begin
    swap     = end_x < start_x;
    x0       = swap ? end_x : start_x;
    y0       = swap ? end_y : start_y;
    x1       = swap ? start_x : end_x;
    y1       = swap ? start_y : end_y;
    adx      = x1 - x0;
    down_nxt = y1 < y0;
    ady      = down_nxt ? (y0 - y1) : (y1 - y0);
    steep_nxt = ady > adx;
    major    = steep_nxt ? ady : adx;
    minor    = steep_nxt ? adx : ady;
    major_d  = mlr_pkg::to_dec(major);
    minor_d  = mlr_pkg::to_dec(minor);
    tie_ld   = !steep_nxt && down_nxt;
    stop_nxt = steep_nxt ? y1 : x1;
    if (tie_ld) begin
      dec_nxt  = (minor_d <<< 1) - major_d;
      keep_nxt = minor_d <<< 1;
      move_nxt = (minor_d <<< 1) - (major_d <<< 1);
    end else begin
      dec_nxt  = major_d - (minor_d <<< 1);
      keep_nxt = -(minor_d <<< 1);
      move_nxt = (major_d <<< 1) - (minor_d <<< 1);
    end
  end

  // step logic
  assign tie  = !steep_r && down_r;
  assign move = tie ? (dec_r >= 0) : (dec_r < 0);

  always_comb begin
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    if (steep_r) begin
      cur_y_nxt = down_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
      if (move) cur_x_nxt = cur_x_r + 1'b1;
    end else begin
      cur_x_nxt = cur_x_r + 1'b1;
      if (move) cur_y_nxt = down_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= '0;
      cur_y_r <= '0;
      stop_r  <= '0;
      dec_r   <= '0;
      keep_r  <= '0;
      move_r  <= '0;
      down_r  <= 1'b0;
      steep_r <= 1'b0;
    end else if (cmd.load) begin
      cur_x_r <= x0;
      cur_y_r <= y0;
      stop_r  <= stop_nxt;
      dec_r   <= dec_nxt;
      keep_r  <= keep_nxt;
      move_r  <= move_nxt;
      down_r  <= down_nxt;
      steep_r <= steep_nxt;
    end else if (cmd.step) begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      dec_r   <= dec_r + (move ? move_r : keep_r);
    end
  end

  assign sts.last = steep_r ? (cur_y_r == stop_r) : (cur_x_r == stop_r);
  assign pixel_x  = cur_x_r;
  assign pixel_y  = cur_y_r;

endmodule

// ----- hw/rtl/mlr_checker.sv -----
// mlr_checker: port-level assertions for midpoint_line_rasterizer, with
// the bind that attaches it. Depends on mlr_pkg.
`timescale 1ns / 1ps

module mlr_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input mlr_pkg::coord_t start_x,
  input mlr_pkg::coord_t end_x,
  input logic            out_valid,
  input logic            out_ready,
  input mlr_pkg::coord_t pixel_x,
  input mlr_pkg::coord_t pixel_y,
  input logic            last_pixel
);

  logic in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready && out_valid)
    else $error("segment transaction did not start a walk");

  a_first_pixel_x: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> pixel_x == $past((end_x < start_x) ? end_x : start_x))
    else $error("first pixel not at leftmost endpoint");

  a_walk_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && !last_pixel |=> out_valid && !in_ready)
    else $error("walk ended before last pixel");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && last_pixel |=> in_ready && !out_valid)
    else $error("not idle after last pixel");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y))
    else $error("pixel changed under stall");

endmodule

bind midpoint_line_rasterizer mlr_checker u_mlr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_seg.valid),
  .in_ready  (in_seg.ready),
  .start_x   (in_seg.start_x),
  .end_x     (in_seg.end_x),
  .out_valid (out_pix.valid),
  .out_ready (out_pix.ready),
  .pixel_x   (out_pix.pixel_x),
  .pixel_y   (out_pix.pixel_y),
  .last_pixel(out_pix.last_pixel)
);
